// ----- sv/assert_macros.svh -----
// Assertion macros used by the controller of the accumulator CPU core.
// Relies on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACPU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACPU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/acpu_pkg.sv -----
// Shared types, opcode constants and decode functions of the accumulator CPU core.
// No dependencies; imported by the controller, the datapath and the top level.
package acpu_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int DW        = 8;

  localparam logic [DW-1:0] OP_AND  = 8'h01;
  localparam logic [DW-1:0] OP_ADD  = 8'h02;
  localparam logic [DW-1:0] OP_SUB  = 8'h03;
  localparam logic [DW-1:0] OP_LDA  = 8'h04;
  localparam logic [DW-1:0] OP_STA  = 8'h08;
  localparam logic [DW-1:0] OP_BUN  = 8'h10;
  localparam logic [DW-1:0] OP_ISZ  = 8'h20;
  localparam logic [DW-1:0] OP_CLA  = 8'h41;
  localparam logic [DW-1:0] OP_CMA  = 8'h42;
  localparam logic [DW-1:0] OP_ASL  = 8'h44;
  localparam logic [DW-1:0] OP_ASR  = 8'h48;
  localparam logic [DW-1:0] OP_INC  = 8'h50;
  localparam logic [DW-1:0] OP_HALT = 8'h60;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_EXEC  = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ADR_CLR,
    ADR_ARG,
    ADR_PC,
    ADR_PC1,
    ADR_RDATA,
    ADR_EA
  } adr_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_DATA,
    WD_ACC,
    WD_INC
  } wd_sel_e;

  typedef struct packed {
    logic     latch;
    logic     ram_en;
    logic     ram_we;
    adr_sel_e adr_sel;
    wd_sel_e  wd_sel;
    logic     clr_step;
    logic     start_pc;
    logic     rd_cap;
    logic     op_cap;
    logic     ea_step;
    logic     alu_step;
    logic     skip_step;
  } acpu_cmd_t;

  typedef struct packed {
    func_e func;
    logic  stopped;
    logic  op_mem;
    logic  op_ind;
    logic  base_bun;
    logic  base_sta;
    logic  base_isz;
    logic  isz_zero;
    logic  clr_last;
  } acpu_sts_t;

  // Memory operation, direct or indirect: the low seven bits name a defined base.
  function automatic logic mem_ok(input logic [DW-1:0] op);
    logic [DW-1:0] base;
    base = {1'b0, op[DW-2:0]};
    return base inside {OP_AND, OP_ADD, OP_SUB, OP_LDA, OP_STA, OP_BUN, OP_ISZ};
  endfunction

  function automatic logic reg_ok(input logic [DW-1:0] op);
    return op inside {OP_CLA, OP_CMA, OP_ASL, OP_ASR, OP_INC};
  endfunction

  function automatic logic [DW-1:0] reg_alu(input logic [DW-1:0] op,
                                            input logic [DW-1:0] acc);
    logic [DW-1:0] res;
    case (op)
      OP_CLA:  res = '0;
      OP_CMA:  res = ~acc;
      OP_ASL:  res = {acc[DW-2:0], 1'b0};
      OP_ASR:  res = {1'b0, acc[DW-1:1]};
      OP_INC:  res = acc + DW'(1);
      default: res = acc;
    endcase
    return res;
  endfunction

  function automatic logic one_byte(input logic [DW-1:0] op);
    return op inside {[OP_CLA:OP_HALT]};
  endfunction

endpackage

// ----- sv/accumulator_cpu_core_unit.sv -----
// Top level of the 8-bit accumulator CPU core with a 256-byte memory.
// Instantiates acpu_ctrl, acpu_dp and acpu_ram; uses acpu_pkg.

// After reset the core sweeps the memory to zero, one byte a cycle, with busy high.
// A transaction is accepted when start is high and busy is low; its result appears
// for exactly one cycle with done_o high and cannot be held off. All work goes
// through one single-port memory with registered read data, one access a cycle.
// States after acceptance: S_DISP only for load, start, or execute while halted or
// faulted; then S_READ for read, S_OP for register operations, halt and undefined
// opcodes; S_OP, S_ADR for STA and BUN, plus S_DAT for AND, ADD, SUB, LDA and ISZ;
// S_IND for an indirect form, S_ISZ and S_SKIP when ISZ skips. busy drops in the
// cycle that carries done_o, so the next transaction may start then.
module accumulator_cpu_core_unit import acpu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [DW-1:0]     data_i,
  output logic              done_o,
  output logic [DW-1:0]     acc_o,
  output logic [MEM_AW-1:0] pc_o,
  output logic [DW-1:0]     opcode_o,
  output logic [DW-1:0]     read_data_o,
  output logic              halted_o,
  output logic              fault_o
);

  acpu_cmd_t         cmd;
  acpu_sts_t         sts;
  logic [MEM_AW-1:0] ram_addr;
  logic [DW-1:0]     ram_wdata;
  logic [DW-1:0]     ram_rdata;

  acpu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  acpu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .acc_o       (acc_o),
    .pc_o        (pc_o),
    .opcode_o    (opcode_o),
    .read_data_o (read_data_o),
    .halted_o    (halted_o),
    .fault_o     (fault_o)
  );

  acpu_ram #(
    .WIDTH (DW),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (cmd.ram_en),
    .we_i    (cmd.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- sv/acpu_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module acpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/acpu_dp.sv -----
// Datapath of the accumulator CPU core: architectural registers, operand and
// address registers, memory address and write data selection. Uses acpu_pkg.
module acpu_dp import acpu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        func_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [DW-1:0]     data_i,
  input  acpu_cmd_t         cmd_i,
  output acpu_sts_t         sts_o,
  output logic [MEM_AW-1:0] ram_addr_o,
  output logic [DW-1:0]     ram_wdata_o,
  input  logic [DW-1:0]     ram_rdata_i,
  output logic [DW-1:0]     acc_o,
  output logic [MEM_AW-1:0] pc_o,
  output logic [DW-1:0]     opcode_o,
  output logic [DW-1:0]     read_data_o,
  output logic              halted_o,
  output logic              fault_o
);

  logic [DW-1:0]     acc_q, acc_d;
  logic [MEM_AW-1:0] pc_q, pc_d;
  logic              halted_q, halted_d;
  logic              fault_q, fault_d;
  logic [DW-1:0]     opcode_q, opcode_d;
  logic [DW-1:0]     rdata_q, rdata_d;
  logic [MEM_AW-1:0] clr_q;
  func_e             func_q;
  logic [MEM_AW-1:0] addr_q;
  logic [DW-1:0]     data_q;
  logic [MEM_AW-1:0] ea_q;
  logic [DW-1:0]     op_base;

  assign op_base = {1'b0, opcode_q[DW-2:0]};

  always_comb begin
    acc_d    = acc_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    fault_d  = fault_q;
    opcode_d = opcode_q;
    rdata_d  = rdata_q;
    if (cmd_i.latch) begin
      opcode_d = '0;
      rdata_d  = '0;
    end
    if (cmd_i.start_pc) begin
      pc_d     = addr_q;
      halted_d = 1'b0;
      fault_d  = 1'b0;
    end
    if (cmd_i.rd_cap) begin
      rdata_d = ram_rdata_i;
    end
    if (cmd_i.op_cap) begin
      opcode_d = ram_rdata_i;
      pc_d     = pc_q + MEM_AW'(1);
      if (ram_rdata_i == OP_HALT) begin
        halted_d = 1'b1;
      end else if (reg_ok(ram_rdata_i)) begin
        acc_d = reg_alu(ram_rdata_i, acc_q);
      end else if (!mem_ok(ram_rdata_i)) begin
        fault_d = 1'b1;
      end
    end
    if (cmd_i.ea_step) begin
      pc_d = (op_base == OP_BUN) ? ram_rdata_i[MEM_AW-1:0] : pc_q + MEM_AW'(1);
    end
    if (cmd_i.alu_step) begin
      case (op_base)
        OP_AND:  acc_d = acc_q & ram_rdata_i;
        OP_ADD:  acc_d = acc_q + ram_rdata_i;
        OP_SUB:  acc_d = acc_q - ram_rdata_i;
        OP_LDA:  acc_d = ram_rdata_i;
        default: acc_d = acc_q;
      endcase
    end
    if (cmd_i.skip_step) begin
      pc_d = pc_q + (one_byte(ram_rdata_i) ? MEM_AW'(1) : MEM_AW'(2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      fault_q  <= 1'b0;
      opcode_q <= '0;
      rdata_q  <= '0;
      clr_q    <= '0;
    end else begin
      acc_q    <= acc_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      fault_q  <= fault_d;
      opcode_q <= opcode_d;
      rdata_q  <= rdata_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_e'(func_i);
      addr_q <= addr_i;
      data_q <= data_i;
    end
    if (cmd_i.ea_step) begin
      ea_q <= ram_rdata_i[MEM_AW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.adr_sel)
      ADR_CLR:   ram_addr_o = clr_q;
      ADR_ARG:   ram_addr_o = addr_q;
      ADR_PC:    ram_addr_o = pc_q;
      ADR_PC1:   ram_addr_o = pc_q + MEM_AW'(1);
      ADR_RDATA: ram_addr_o = ram_rdata_i[MEM_AW-1:0];
      ADR_EA:    ram_addr_o = ea_q;
      default:   ram_addr_o = pc_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_ZERO: ram_wdata_o = '0;
      WD_DATA: ram_wdata_o = data_q;
      WD_ACC:  ram_wdata_o = acc_q;
      WD_INC:  ram_wdata_o = ram_rdata_i + DW'(1);
      default: ram_wdata_o = '0;
    endcase
  end

  assign sts_o.func     = func_q;
  assign sts_o.stopped  = halted_q | fault_q;
  assign sts_o.op_mem   = mem_ok(ram_rdata_i);
  assign sts_o.op_ind   = opcode_q[DW-1];
  assign sts_o.base_bun = (op_base == OP_BUN);
  assign sts_o.base_sta = (op_base == OP_STA);
  assign sts_o.base_isz = (op_base == OP_ISZ);
  assign sts_o.isz_zero = (ram_rdata_i == {DW{1'b1}});
  assign sts_o.clr_last = (clr_q == MEM_AW'(MEM_DEPTH - 1));

  assign acc_o       = acc_q;
  assign pc_o        = pc_q;
  assign opcode_o    = opcode_q;
  assign read_data_o = rdata_q;
  assign halted_o    = halted_q;
  assign fault_o     = fault_q;

endmodule

// ----- sv/acpu_ctrl.sv -----
// Controller of the accumulator CPU core: sequences the memory clear, the
// command dispatch and the instruction steps. Uses acpu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acpu_ctrl import acpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output acpu_cmd_t cmd_o,
  input  acpu_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_READ,
    S_OP,
    S_ADR,
    S_IND,
    S_DAT,
    S_ISZ,
    S_SKIP
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.ram_en   = 1'b1;
        cmd_o.ram_we   = 1'b1;
        cmd_o.adr_sel  = ADR_CLR;
        cmd_o.wd_sel   = WD_ZERO;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func)
          FUNC_LOAD: begin
            cmd_o.ram_en  = 1'b1;
            cmd_o.ram_we  = 1'b1;
            cmd_o.adr_sel = ADR_ARG;
            cmd_o.wd_sel  = WD_DATA;
            state_d       = S_IDLE;
            done_d        = 1'b1;
          end
          FUNC_START: begin
            cmd_o.start_pc = 1'b1;
            state_d        = S_IDLE;
            done_d         = 1'b1;
          end
          FUNC_READ: begin
            cmd_o.ram_en  = 1'b1;
            cmd_o.adr_sel = ADR_ARG;
            state_d       = S_READ;
          end
          default: begin
            if (sts_i.stopped) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              cmd_o.ram_en  = 1'b1;
              cmd_o.adr_sel = ADR_PC;
              state_d       = S_OP;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_IDLE;
        done_d       = 1'b1;
      end
      S_OP: begin
        cmd_o.op_cap = 1'b1;
        if (sts_i.op_mem) begin
          cmd_o.ram_en  = 1'b1;
          cmd_o.adr_sel = ADR_PC1;
          state_d       = S_ADR;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_ADR, S_IND: begin
        if (state_q == S_ADR && sts_i.op_ind) begin
          cmd_o.ram_en  = 1'b1;
          cmd_o.adr_sel = ADR_RDATA;
          state_d       = S_IND;
        end else begin
          cmd_o.ea_step = 1'b1;
          cmd_o.adr_sel = ADR_RDATA;
          cmd_o.wd_sel  = WD_ACC;
          if (sts_i.base_bun) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else if (sts_i.base_sta) begin
            cmd_o.ram_en = 1'b1;
            cmd_o.ram_we = 1'b1;
            state_d      = S_IDLE;
            done_d       = 1'b1;
          end else begin
            cmd_o.ram_en = 1'b1;
            state_d      = S_DAT;
          end
        end
      end
      S_DAT: begin
        if (sts_i.base_isz) begin
          cmd_o.ram_en  = 1'b1;
          cmd_o.ram_we  = 1'b1;
          cmd_o.adr_sel = ADR_EA;
          cmd_o.wd_sel  = WD_INC;
          if (sts_i.isz_zero) begin
            state_d = S_ISZ;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end else begin
          cmd_o.alu_step = 1'b1;
          state_d        = S_IDLE;
          done_d         = 1'b1;
        end
      end
      S_ISZ: begin
        cmd_o.ram_en  = 1'b1;
        cmd_o.adr_sel = ADR_PC;
        state_d       = S_SKIP;
      end
      S_SKIP: begin
        cmd_o.skip_step = 1'b1;
        state_d         = S_IDLE;
        done_d          = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `ACPU_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "strobe outside idle")
  `ACPU_ASSERT_NXT(a_accept_disp, (state_q == S_IDLE) && start_i, state_q == S_DISP, "no dispatch")
  `ACPU_ASSERT_IMP(a_we_en, cmd_o.ram_we, cmd_o.ram_en, "write without enable")
  `ACPU_ASSERT_NXT(a_isz_skip, state_q == S_ISZ, state_q == S_SKIP, "skip step lost")
  `ACPU_ASSERT_IMP(a_clear_quiet, state_q == S_CLEAR, !done_q && !cmd_o.latch, "busy clear")

endmodule
